// ===== hdl/ddsf_pkg.sv =====
package ddsf_pkg;

	// field and register widths
	localparam int SPEED_W = 16;
	localparam int MAG_W   = SPEED_W + 1;
	localparam int STEP_W  = 16;
	localparam int GAIN_W  = 20;
	localparam int MODE_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GAIN_W;

	// register reset values
	localparam logic [STEP_W-1:0] DEAD_ZONE_RST = 16'd205;
	localparam logic [GAIN_W-1:0] STEP_GAIN_RST = 20'd20480;
	localparam logic [STEP_W-1:0] MIN_STEPS_RST = 16'd2;
	localparam logic [MODE_W-1:0] MODE_BYTE_RST = 8'd1;

	// frame constants
	localparam logic [BYTE_W-1:0] FRAME_SYNC     = 8'hAA;
	localparam logic [BYTE_W-1:0] MOTOR_LEFT_ID  = 8'h01;
	localparam logic [BYTE_W-1:0] MOTOR_RIGHT_ID = 8'h02;
	localparam logic [STEP_W-1:0] STEPS_MAX      = '1;

	// divider: gain[19:16] seeds the remainder, low 16 bits shifted in two a cycle
	localparam int DIV_BITS_PER_CYC = 2;
	localparam int DIV_ITERS        = STEP_W / DIV_BITS_PER_CYC;
	localparam int DIV_CNT_W        = $clog2(DIV_ITERS);
	localparam int GAIN_HI_W        = GAIN_W - STEP_W;

	localparam int CMD_FIFO_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEAD_ZONE = 2'd0,
		CFG_STEP_GAIN = 2'd1,
		CFG_MIN_STEPS = 2'd2,
		CFG_MODE_BYTE = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_IDLE = 2'd0,
		DIV_RUN  = 2'd1,
		DIV_DONE = 2'd2
	} div_state_t;

	typedef enum logic [2:0] {
		POS_SYNC = 3'd0,
		POS_ID   = 3'd1,
		POS_MODE = 3'd2,
		POS_DIR  = 3'd3,
		POS_HI   = 3'd4,
		POS_LO   = 3'd5
	} frame_pos_t;

	// classified command, front to back
	typedef struct packed {
		logic             stop;
		logic             ldir;
		logic             rdir;
		logic [MAG_W-1:0] lmag;
		logic [MAG_W-1:0] rmag;
	} cmd_t;

	// step settings for the divider
	typedef struct packed {
		logic [STEP_W-1:0] dead_zone;
		logic [GAIN_W-1:0] step_gain;
		logic [STEP_W-1:0] min_steps;
	} div_cfg_t;

	// finished wheel settings, divider to serializer
	typedef struct packed {
		logic              ldir;
		logic              rdir;
		logic [STEP_W-1:0] lsteps;
		logic [STEP_W-1:0] rsteps;
	} wheel_res_t;

	// one restoring division step: returns {quotient bit, new remainder}
	function automatic logic [MAG_W:0] div_bit(input logic [MAG_W-1:0] rem,
		input logic [MAG_W-1:0] mag, input logic b);
		logic [MAG_W:0] t;
		logic [MAG_W:0] d;
		t = {rem, b};
		d = t - {1'b0, mag};
		if (t >= {1'b0, mag}) begin
			div_bit = {1'b1, d[MAG_W-1:0]};
		end else begin
			div_bit = {1'b0, t[MAG_W-1:0]};
		end
	endfunction

	// saturation, dead zone and lower clamp on a quotient
	function automatic logic [STEP_W-1:0] finish_steps(input logic zero, input logic sat,
		input logic [STEP_W-1:0] quo, input logic [STEP_W-1:0] min_steps);
		logic [STEP_W-1:0] q;
		q = sat ? STEPS_MAX : quo;
		if (q < min_steps) begin
			q = min_steps;
		end
		finish_steps = zero ? '0 : q;
	endfunction

endpackage

// ===== hdl/ddsf_front.sv =====
module ddsf_front
	import ddsf_pkg::*;
(
	input  logic               command,
	input  logic [SPEED_W-1:0] linear_speed,
	input  logic [SPEED_W-1:0] angular_speed,
	output cmd_t               cmd
);

	logic signed [MAG_W-1:0] left;
	logic signed [MAG_W-1:0] right;
	logic [MAG_W-1:0] left_neg;
	logic [MAG_W-1:0] right_neg;

	// 17-bit sums cannot overflow
	assign left  = $signed({linear_speed[SPEED_W-1], linear_speed})
		- $signed({angular_speed[SPEED_W-1], angular_speed});
	assign right = $signed({linear_speed[SPEED_W-1], linear_speed})
		+ $signed({angular_speed[SPEED_W-1], angular_speed});
	assign left_neg  = -left;
	assign right_neg = -right;

	always_comb begin
		cmd.stop = command;
		if (command) begin
			cmd.ldir = 1'b0;
			cmd.rdir = 1'b1;
		end else begin
			cmd.ldir = ~left[MAG_W-1];
			cmd.rdir = right[MAG_W-1];
		end
		// magnitude of -65536 reads correctly as unsigned 17 bits
		cmd.lmag = left[MAG_W-1] ? left_neg : left;
		cmd.rmag = right[MAG_W-1] ? right_neg : right;
	end

endmodule

// ===== hdl/ddsf_cmd_fifo.sv =====
module ddsf_cmd_fifo
	import ddsf_pkg::*;
#(
	parameter int DEPTH = CMD_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/ddsf_div.sv =====
module ddsf_div
	import ddsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  div_cfg_t   cfg,
	input  cmd_t       cmd,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	output wheel_res_t res,
	output logic       res_valid,
	input  logic       res_ready
);

	div_state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] iter_q;
	logic [STEP_W-1:0]    dvd_q;
	logic [MAG_W-1:0]     lmag_q, rmag_q;
	logic [MAG_W-1:0]     lrem_q, rrem_q;
	logic [STEP_W-1:0]    lquo_q, rquo_q;
	logic                 lzero_q, rzero_q, lsat_q, rsat_q;
	logic                 ldir_q, rdir_q;

	logic [MAG_W:0] l_a, l_b, r_a, r_b;
	logic [MAG_W-1:0] gain_hi;

	assign gain_hi = MAG_W'(cfg.step_gain[GAIN_W-1:STEP_W]);

	// two quotient bits a cycle per lane
	assign l_a = div_bit(lrem_q, lmag_q, dvd_q[STEP_W-1]);
	assign l_b = div_bit(l_a[MAG_W-1:0], lmag_q, dvd_q[STEP_W-2]);
	assign r_a = div_bit(rrem_q, rmag_q, dvd_q[STEP_W-1]);
	assign r_b = div_bit(r_a[MAG_W-1:0], rmag_q, dvd_q[STEP_W-2]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (!cmd_empty) begin
					state_d = cmd.stop ? DIV_DONE : DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (iter_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: begin
				if (res_ready) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = (state_q == DIV_IDLE) && !cmd_empty;
		res_valid = (state_q == DIV_DONE);
		res.ldir   = ldir_q;
		res.rdir   = rdir_q;
		res.lsteps = finish_steps(lzero_q, lsat_q, lquo_q, cfg.min_steps);
		res.rsteps = finish_steps(rzero_q, rsat_q, rquo_q, cfg.min_steps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DIV_RUN) begin
				iter_q <= iter_q + 1'b1;
			end else begin
				iter_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ldir_q  <= cmd.ldir;
			rdir_q  <= cmd.rdir;
			lmag_q  <= cmd.lmag;
			rmag_q  <= cmd.rmag;
			lzero_q <= cmd.stop || (cmd.lmag < MAG_W'(cfg.dead_zone));
			rzero_q <= cmd.stop || (cmd.rmag < MAG_W'(cfg.dead_zone));
			// quotient would not fit 16 bits, zero magnitude included
			lsat_q  <= (gain_hi >= cmd.lmag);
			rsat_q  <= (gain_hi >= cmd.rmag);
			lrem_q  <= gain_hi;
			rrem_q  <= gain_hi;
			dvd_q   <= cfg.step_gain[STEP_W-1:0];
			lquo_q  <= '0;
			rquo_q  <= '0;
		end else if (state_q == DIV_RUN) begin
			lrem_q <= l_b[MAG_W-1:0];
			rrem_q <= r_b[MAG_W-1:0];
			lquo_q <= {lquo_q[STEP_W-3:0], l_a[MAG_W], l_b[MAG_W]};
			rquo_q <= {rquo_q[STEP_W-3:0], r_a[MAG_W], r_b[MAG_W]};
			dvd_q  <= {dvd_q[STEP_W-3:0], 2'b00};
		end
	end

endmodule

// ===== hdl/ddsf_ser.sv =====
module ddsf_ser
	import ddsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MODE_W-1:0] mode_byte,
	input  wheel_res_t        res,
	input  logic              res_valid,
	output logic              res_ready,
	output logic [BYTE_W-1:0] frame_byte,
	output logic              last_byte,
	output logic              empty,
	input  logic              pop
);

	logic       busy_q;
	logic       motor_q;
	frame_pos_t pos_q, pos_next;
	wheel_res_t res_q;
	logic       load;
	logic       dir;
	logic [STEP_W-1:0] steps;

	assign empty     = ~busy_q;
	assign last_byte = motor_q && (pos_q == POS_LO);
	assign load      = res_valid && (!busy_q || (pop && last_byte));
	assign res_ready = load;
	assign dir       = motor_q ? res_q.rdir : res_q.ldir;
	assign steps     = motor_q ? res_q.rsteps : res_q.lsteps;

	always_comb begin
		case (pos_q)
			POS_SYNC: frame_byte = FRAME_SYNC;
			POS_ID:   frame_byte = motor_q ? MOTOR_RIGHT_ID : MOTOR_LEFT_ID;
			POS_MODE: frame_byte = mode_byte;
			POS_DIR:  frame_byte = {{(BYTE_W-1){1'b0}}, dir};
			POS_HI:   frame_byte = steps[STEP_W-1:BYTE_W];
			POS_LO:   frame_byte = steps[BYTE_W-1:0];
			default:  frame_byte = FRAME_SYNC;
		endcase
	end

	always_comb begin
		case (pos_q)
			POS_SYNC: pos_next = POS_ID;
			POS_ID:   pos_next = POS_MODE;
			POS_MODE: pos_next = POS_DIR;
			POS_DIR:  pos_next = POS_HI;
			POS_HI:   pos_next = POS_LO;
			POS_LO:   pos_next = POS_SYNC;
			default:  pos_next = POS_SYNC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			motor_q <= 1'b0;
			pos_q   <= POS_SYNC;
		end else if (load) begin
			busy_q  <= 1'b1;
			motor_q <= 1'b0;
			pos_q   <= POS_SYNC;
		end else if (busy_q && pop) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end
			if (pos_q == POS_LO) begin
				motor_q <= ~motor_q;
			end
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== hdl/diff_drive_step_frame_gen.sv =====
// differential drive mixer with stepper frame output. each command pushed in
// (drive with signed q3.12 linear/angular speeds, or stop) comes out as twelve
// bytes, one transfer per byte: two frames {0xAA, motor id, mode, direction,
// steps high, steps low}, left motor (id 1) then right motor (id 2), with
// last_byte set on the twelfth. the step value per wheel is
// floor(step_gain / |speed|), 0 inside the dead zone, saturated at 65535 and
// clamped below at min_steps. the output side drains one byte per clock while
// pop stays high; the two-lane step divider (two quotient bits per cycle)
// works on the next command while the current frames are still going out, and
// a stop skips the division. configuration (dead zone 205, gain 20480, min
// steps 2, mode 1 after reset) is written through cfg_valid/cfg_ready, which
// is always ready; write it only while no command is in flight
module diff_drive_step_frame_gen
	import ddsf_pkg::*;
#(
	parameter int FIFO_DEPTH = CMD_FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command queue side
	input  logic                  push,
	output logic                  full,
	input  logic                  command,
	input  logic [SPEED_W-1:0]    linear_speed,
	input  logic [SPEED_W-1:0]    angular_speed,
	// byte stream side
	output logic                  empty,
	input  logic                  pop,
	output logic [BYTE_W-1:0]     frame_byte,
	output logic                  last_byte,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [STEP_W-1:0] dead_zone_q;
	logic [GAIN_W-1:0] step_gain_q;
	logic [STEP_W-1:0] min_steps_q;
	logic [MODE_W-1:0] mode_byte_q;

	cmd_t       front_cmd;
	cmd_t       fifo_cmd;
	logic       fifo_empty;
	logic       fifo_pop;
	div_cfg_t   div_cfg;
	wheel_res_t wheel_res;
	logic       res_valid;
	logic       res_ready;

	// register file, no backpressure on writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RST;
			step_gain_q <= STEP_GAIN_RST;
			min_steps_q <= MIN_STEPS_RST;
			mode_byte_q <= MODE_BYTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEAD_ZONE: dead_zone_q <= cfg_data[STEP_W-1:0];
				CFG_STEP_GAIN: step_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_MIN_STEPS: min_steps_q <= cfg_data[STEP_W-1:0];
				CFG_MODE_BYTE: mode_byte_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign div_cfg.dead_zone = dead_zone_q;
	assign div_cfg.step_gain = step_gain_q;
	assign div_cfg.min_steps = min_steps_q;

	// front: wheel speeds, directions and magnitudes
	ddsf_front u_front (
		.command       (command),
		.linear_speed  (linear_speed),
		.angular_speed (angular_speed),
		.cmd           (front_cmd)
	);

	// short queue decoupling the front from the divider
	ddsf_cmd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !full),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (fifo_pop),
		.rd_data (fifo_cmd),
		.empty   (fifo_empty)
	);

	// back: step divider for both wheels
	ddsf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (div_cfg),
		.cmd       (fifo_cmd),
		.cmd_empty (fifo_empty),
		.cmd_pop   (fifo_pop),
		.res       (wheel_res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	// back: frame serializer, holds the byte under transfer
	ddsf_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_byte  (mode_byte_q),
		.res        (wheel_res),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ===== verif/tb_diff_drive_step_frame_gen.sv =====
module tb_diff_drive_step_frame_gen;
	import ddsf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// command codes on the command port
	localparam logic CMD_DRIVE = 1'b0;
	localparam logic CMD_STOP  = 1'b1;

	// frame layout, written out independently of the design package
	localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
	localparam logic [7:0]  LEFT_MOTOR  = 8'h01;
	localparam logic [7:0]  RIGHT_MOTOR = 8'h02;
	localparam logic [19:0] STEP_SAT    = 20'd65535;

	// run control
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;

	// one byte of the serial stream as the receiver should see it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	// directed stimulus row: either a register setting or one command,
	// optionally with its wheel values typed in by hand
	typedef enum logic {
		ROW_ITEM,
		ROW_REGS
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        cmd;
		logic [15:0] lin;
		logic [15:0] ang;
		logic        known;
		logic        ldir;
		logic        rdir;
		logic [15:0] lsteps;
		logic [15:0] rsteps;
		logic [19:0] dz;
		logic [19:0] gain;
		logic [19:0] mn;
		logic [19:0] md;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic                  command = CMD_DRIVE;
	logic [SPEED_W-1:0]    linear_speed = '0;
	logic [SPEED_W-1:0]    angular_speed = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [BYTE_W-1:0]     frame_byte;
	logic                  last_byte;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEAD_ZONE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the register file, updated on each register transfer
	logic [15:0] cur_dz   = 16'd205;
	logic [19:0] cur_gain = 20'd20480;
	logic [15:0] cur_min  = 16'd2;
	logic [7:0]  cur_mode = 8'd1;

	out_byte_t frame_q[$];
	row_t      dir_tab[$];

	int err_cnt = 0;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// long receiver hold-off, armed once by the stimulus thread
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;
	int   hold_cnt = 0;

	diff_drive_step_frame_gen u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.linear_speed (linear_speed),
		.angular_speed(angular_speed),
		.empty        (empty),
		.pop          (pop),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// step period for one wheel speed (17 bit signed, cannot overflow)
	function automatic logic [15:0] step_period(logic signed [16:0] spd);
		logic [16:0] mag;
		logic [19:0] q;
		mag = spd[16] ? 17'(-spd) : 17'(spd);
		// inside the dead zone the wheel stands still
		if (mag < 17'(cur_dz)) begin
			return '0;
		end
		// zero speed with zero dead zone: divide by zero reads as infinite
		if (mag == '0) begin
			q = STEP_SAT;
		end else begin
			q = cur_gain / mag;
		end
		if (q > STEP_SAT) begin
			q = STEP_SAT;
		end
		// lower clamp comes after saturation, so it also lifts a zero gain
		if (q < 20'(cur_min)) begin
			q = 20'(cur_min);
		end
		return q[15:0];
	endfunction

	// lay out both motor frames and queue the twelve bytes
	function automatic void queue_frames(logic ldir, logic rdir, logic [15:0] ls,
		logic [15:0] rs);
		logic [7:0] b[12];
		b = '{SYNC_BYTE, LEFT_MOTOR, cur_mode, {7'd0, ldir}, ls[15:8], ls[7:0],
			SYNC_BYTE, RIGHT_MOTOR, cur_mode, {7'd0, rdir}, rs[15:8], rs[7:0]};
		foreach (b[i]) begin
			frame_q.push_back('{data: b[i], last: (i == 11)});
		end
	endfunction

	// mix linear/angular into wheel speeds and queue the resulting frames
	function automatic void mix_to_frames(logic cmd, logic signed [15:0] lin,
		logic signed [15:0] ang);
		logic signed [16:0] lsum;
		logic signed [16:0] rsum;
		if (cmd == CMD_STOP) begin
			// stop: left reverse flag 0, right flag 1, both wheels zero
			queue_frames(1'b0, 1'b1, '0, '0);
		end else begin
			lsum = lin - ang;
			rsum = lin + ang;
			// left direction is 1 going forward, right is mirrored
			queue_frames(~lsum[16], rsum[16], step_period(lsum), step_period(rsum));
		end
	endfunction

	// ------------------------------------------------------------------
	// directed table builders
	// ------------------------------------------------------------------

	function automatic row_t row_drive(int lin, int ang);
		row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.cmd = CMD_DRIVE;
		r.lin = lin[15:0];
		r.ang = ang[15:0];
		return r;
	endfunction

	function automatic row_t row_known(int lin, int ang, bit ldir, bit rdir, int ls,
		int rs);
		row_t r;
		r = row_drive(lin, ang);
		r.known = 1'b1;
		r.ldir = ldir;
		r.rdir = rdir;
		r.lsteps = ls[15:0];
		r.rsteps = rs[15:0];
		return r;
	endfunction

	function automatic row_t row_stop();
		row_t r;
		r = row_known(0, 0, 1'b0, 1'b1, 0, 0);
		r.cmd = CMD_STOP;
		return r;
	endfunction

	function automatic row_t row_regs(int dz, int gain, int mn, int md);
		row_t r;
		r = '0;
		r.kind = ROW_REGS;
		r.dz = dz[19:0];
		r.gain = gain[19:0];
		r.mn = mn[19:0];
		r.md = md[19:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one command transfer; push stays high afterwards so back-to-back
	// commands need no gap, whoever waits next lowers it first
	task automatic send_item(logic cmd, logic [15:0] lin, logic [15:0] ang,
		logic known, logic ldir, logic rdir, logic [15:0] ls, logic [15:0] rs);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		linear_speed <= lin;
		angular_speed <= ang;
		do begin
			@(posedge clk);
		end while (full);
		// transfer done at this edge, results cannot show before the next one
		if (known) begin
			queue_frames(ldir, rdir, ls, rs);
		end else begin
			mix_to_frames(cmd, lin, ang);
		end
	endtask

	// sender pause until every queued byte has been taken
	task automatic wait_frames_out();
		push <= 1'b0;
		while (frame_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// one register transfer; cfg_valid is left high like push
	task automatic write_reg(cfg_idx_t idx, logic [19:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		// registers keep only their own width
		case (idx)
			CFG_DEAD_ZONE: cur_dz = d[15:0];
			CFG_STEP_GAIN: cur_gain = d;
			CFG_MIN_STEPS: cur_min = d[15:0];
			CFG_MODE_BYTE: cur_mode = d[7:0];
			default: ;
		endcase
	endtask

	// full register setting, only once the block has gone idle
	task automatic set_config(logic [19:0] dz, logic [19:0] gain, logic [19:0] mn,
		logic [19:0] md);
		wait_frames_out();
		write_reg(CFG_DEAD_ZONE, dz);
		write_reg(CFG_STEP_GAIN, gain);
		write_reg(CFG_MIN_STEPS, mn);
		write_reg(CFG_MODE_BYTE, md);
		cfg_valid <= 1'b0;
	endtask

	// speed with weight on the dead zone edge and the extremes
	function automatic logic [15:0] pick_speed();
		int sel;
		int m;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			return 16'($urandom);
		end else if (sel < 7) begin
			m = $urandom_range(0, 600);
			return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
		end
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			default: return 16'h0000;
		endcase
	endfunction

	task automatic random_items(int n);
		logic        cmd;
		logic [15:0] lin;
		logic [15:0] ang;
		for (int k = 0; k < n; k++) begin
			cmd = ($urandom_range(0, 9) == 0) ? CMD_STOP : CMD_DRIVE;
			lin = pick_speed();
			ang = pick_speed();
			// now and then make one wheel nearly cancel out
			case ($urandom_range(0, 7))
				0: ang = lin + 16'($urandom_range(0, 8)) - 16'd4;
				1: ang = 16'd0 - lin + 16'($urandom_range(0, 8)) - 16'd4;
				default: ;
			endcase
			send_item(cmd, lin, ang, 1'b0, 1'b0, 1'b0, '0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// receiver: random pop, plus one long hold-off counted here
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			pop <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1) begin
				hold_done <= 1'b1;
			end
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// checker: every byte transfer against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_byte_t exp_b;
		if (arst_n && pop && !empty) begin
			if (frame_q.size() == 0) begin
				$error("byte 0x%02h transferred with nothing expected", frame_byte);
				err_cnt++;
			end else begin
				exp_b = frame_q.pop_front();
				if (frame_byte !== exp_b.data) begin
					$error("frame_byte: expected 0x%02h, got 0x%02h", exp_b.data,
						frame_byte);
					err_cnt++;
				end
				if (last_byte !== exp_b.last) begin
					$error("last_byte: expected %0b, got %0b", exp_b.last, last_byte);
					err_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("** diff_drive_step_frame_gen: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		dir_tab = '{
			// reset settings: dead zone 205, gain 20480, min 2, mode 1
			row_stop(),
			row_known(0, 0, 1'b1, 1'b0, 0, 0),
			// full forward: quotient 0, lifted to the minimum
			row_known(32767, 0, 1'b1, 1'b0, 2, 2),
			// left cancels to zero, right reaches -65536
			row_known(-32768, -32768, 1'b1, 1'b1, 0, 2),
			row_known(32767, -32768, 1'b1, 1'b1, 2, 0),
			row_known(-32768, 32767, 1'b0, 1'b1, 2, 0),
			// right on the dead zone edge and just inside it
			row_drive(205, 0),
			row_known(204, 0, 1'b1, 1'b0, 0, 0),
			row_drive(0, -205),
			row_drive(4096, 1024),
			row_stop(),
			// no dead zone, largest gain, no minimum, all-ones mode
			row_regs(0, 20'hFFFFF, 0, 255),
			// zero speed reads as infinite quotient
			row_known(0, 0, 1'b1, 1'b0, 65535, 65535),
			// quotient above 16 bits saturates
			row_known(1, 0, 1'b1, 1'b0, 65535, 65535),
			row_drive(16, 0),
			row_drive(17, 0),
			row_drive(-32768, 0),
			// upper bits beyond each register width are dropped; zero gain
			row_regs(20'hF0064, 0, 7, 20'hABC5A),
			row_known(300, 0, 1'b1, 1'b0, 7, 7),
			row_known(99, 0, 1'b1, 1'b0, 0, 0),
			row_known(0, 0, 1'b1, 1'b0, 0, 0),
			// dead zone of one, minimum at the top of its range
			row_regs(1, 20480, 65535, 0),
			row_known(1, 0, 1'b1, 1'b0, 65535, 65535),
			row_known(0, 0, 1'b1, 1'b0, 0, 0),
			row_drive(-12345, 6789)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, without idling
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_REGS) begin
				set_config(dir_tab[i].dz, dir_tab[i].gain, dir_tab[i].mn, dir_tab[i].md);
			end else begin
				send_item(dir_tab[i].cmd, dir_tab[i].lin, dir_tab[i].ang,
					dir_tab[i].known, dir_tab[i].ldir, dir_tab[i].rdir,
					dir_tab[i].lsteps, dir_tab[i].rsteps);
			end
		end

		// random phase 1: back to reset values, sender 33% idle, receiver 47%
		set_config(20'd205, 20'd20480, 20'd2, 20'd1);
		send_idle_pct = 33;
		recv_idle_pct = 47;
		random_items(130);

		// random phase 2: random settings, idling the other way round
		set_config(20'($urandom_range(0, 800)), 20'($urandom_range(1, 20'hFFFFF)),
			20'($urandom_range(0, 200)), 20'($urandom_range(0, 255)));
		send_idle_pct = 47;
		recv_idle_pct = 33;
		random_items(130);

		// receiver holds off while the sender keeps pushing, so full must
		// rise; then the sender waits for the backlog to drain
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_armed <= 1'b1;
		random_items(24);
		wait_frames_out();

		// random phase 3: another setting, no idling on either side
		set_config(20'($urandom_range(0, 300)), 20'($urandom_range(1, 20'hFFFFF)),
			20'($urandom_range(0, 2000)), 20'($urandom_range(0, 255)));
		random_items(130);

		wait_frames_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("** diff_drive_step_frame_gen: PASSED **");
		end else begin
			$display("** diff_drive_step_frame_gen: FAILED **");
		end
		$finish;
	end

endmodule
